/* hw/rtl/kpc_pkg.sv */
`default_nettype none

package kpc_pkg;

    // Scan tick period in milliseconds.
    localparam int unsigned TICK_MS = 10;

    // Width of the held-time counters and of the thresholds.
    localparam int unsigned TIME_W = 16;

    // Saturation value of the held-time counters.
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Configuration port widths.
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // Stream data widths (whole bytes).
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 8;

    // Reset value of the minimum short-press hold.
    localparam logic [TIME_W-1:0] SHORT_TIME_RESET = TIME_W'(50);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME_A = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME_B = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME  = CFG_IDX_W'(3);

    // Reported event codes.
    typedef enum logic [1:0] {
        EV_SHORT  = 2'd0,
        EV_LONG_A = 2'd1,
        EV_LONG_B = 2'd2
    } event_t;

    // Configuration register contents.
    typedef struct packed {
        logic              press_low;
        logic [TIME_W-1:0] long_time_a;
        logic [TIME_W-1:0] long_time_b;
        logic [TIME_W-1:0] short_time;
    } cfg_t;

    // Key state after the latest tick.
    typedef struct packed {
        logic              pressed_now;
        logic              pressed_before;
        logic [TIME_W-1:0] held_time;
        logic [TIME_W-1:0] held_time_before;
    } key_state_t;

endpackage

`default_nettype wire

/* hw/rtl/kpc_cfg.sv */
`default_nettype none

module kpc_cfg
    import kpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register file; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_low   <= 1'b1;
            cfg_reg.long_time_a <= '0;
            cfg_reg.long_time_b <= '0;
            cfg_reg.short_time  <= SHORT_TIME_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PRESS_LOW:   cfg_reg.press_low   <= cfg_data[0];
                REG_LONG_TIME_A: cfg_reg.long_time_a <= cfg_data[TIME_W-1:0];
                REG_LONG_TIME_B: cfg_reg.long_time_b <= cfg_data[TIME_W-1:0];
                REG_SHORT_TIME:  cfg_reg.short_time  <= cfg_data[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/kpc_track.sv */
`default_nettype none

module kpc_track
    import kpc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic                 press_low,
    input  wire logic                 advance,
    output logic                      pending,
    output key_state_t                key_state
);

    key_state_t        state_reg;
    key_state_t        state_next;
    logic              pending_reg;
    logic              pending_next;
    logic              accept;
    logic              pressed;
    logic [TIME_W:0]   held_sum;

    // A new tick is taken when none is pending or the previous one is judged in this cycle.
    assign s_tready  = !pending_reg || advance;
    assign accept    = s_tvalid && s_tready;
    assign pending   = pending_reg;
    assign key_state = state_reg;

    // Polarity and held-time update for the incoming tick.
    always_comb
    begin
        pressed  = press_low ? !s_tdata[0] : s_tdata[0];
        held_sum = {1'b0, state_reg.held_time} + (TIME_W+1)'(TICK_MS);

        state_next                  = state_reg;
        state_next.pressed_before   = state_reg.pressed_now;
        state_next.held_time_before = state_reg.held_time;
        if (pressed != state_reg.pressed_now)
        begin
            state_next.pressed_now = pressed;
            state_next.held_time   = '0;
        end
        else if (held_sum[TIME_W] || held_sum[TIME_W-1:0] == TIME_MAX)
        begin
            state_next.held_time = TIME_MAX;
        end
        else
        begin
            state_next.held_time = held_sum[TIME_W-1:0];
        end

        if (accept)
        begin
            pending_next = 1'b1;
        end
        else if (advance)
        begin
            pending_next = 1'b0;
        end
        else
        begin
            pending_next = pending_reg;
        end
    end

    // Key state and the flag that marks a tick awaiting judgment.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/kpc_judge.sv */
`default_nettype none

module kpc_judge
    import kpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pending,
    input  wire key_state_t            key_state,
    input  wire cfg_t                  cfg,
    output logic                       advance,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic              valid_reg;
    event_t            event_reg;
    logic              hit;
    event_t            ev;
    logic              swapped;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic              hold_hi;
    logic              hold_short;
    logic              rel_lo_hi;
    logic              rel_short_lo;
    logic              rel_short_hi;
    logic              released;
    event_t            ev_high;
    event_t            ev_low;
    logic              out_free;

    // Order the long thresholds and evaluate the press windows.
    always_comb
    begin
        swapped  = cfg.long_time_b < cfg.long_time_a;
        lo       = swapped ? cfg.long_time_b : cfg.long_time_a;
        hi       = swapped ? cfg.long_time_a : cfg.long_time_b;
        ev_high  = swapped ? EV_LONG_A : EV_LONG_B;
        ev_low   = swapped ? EV_LONG_B : EV_LONG_A;
        released = key_state.pressed_before && !key_state.pressed_now;

        hold_hi      = key_state.pressed_now && key_state.held_time >= hi
                       && key_state.held_time_before < hi;
        hold_short   = key_state.pressed_now && key_state.held_time >= cfg.short_time
                       && key_state.held_time_before < cfg.short_time;
        rel_lo_hi    = released && key_state.held_time_before >= lo
                       && key_state.held_time_before < hi;
        rel_short_lo = released && key_state.held_time_before >= cfg.short_time
                       && key_state.held_time_before < lo;
        rel_short_hi = released && key_state.held_time_before >= cfg.short_time
                       && key_state.held_time_before < hi;

        hit = 1'b0;
        ev  = EV_SHORT;
        if (hi != '0 && lo != '0)
        begin
            if (hold_hi)
            begin
                hit = 1'b1;
                ev  = ev_high;
            end
            else if (rel_lo_hi)
            begin
                hit = 1'b1;
                ev  = ev_low;
            end
            else if (rel_short_lo)
            begin
                hit = 1'b1;
            end
        end
        else if (hi != '0)
        begin
            if (hold_hi)
            begin
                hit = 1'b1;
                ev  = ev_high;
            end
            else if (rel_short_hi)
            begin
                hit = 1'b1;
            end
        end
        else if (hold_short)
        begin
            hit = 1'b1;
        end
    end

    // A judged tick moves on unless its event meets a full output register that is not being emptied.
    assign out_free = !valid_reg || m_tready;
    assign advance  = pending && (!hit || out_free);

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, event_reg};

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            event_reg <= EV_SHORT;
        end
        else if (pending && hit && out_free)
        begin
            valid_reg <= 1'b1;
            event_reg <= ev;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/key_press_classifier.sv */
`default_nettype none

// Short and long key press classifier. Each slave-side transfer is one scan tick
// of 10 ms carrying the raw pin level of one key; the block turns it into a
// pressed flag by the press_low register, tracks how long the key has been in
// its current and previous state (saturating at 65535 ms), and sends a
// master-side transfer for a short press or a long press at threshold a or b.
// A threshold of zero disables that long press; with both at zero a short press
// is reported while the key is still held. One tick is taken every clock cycle
// while the output does not stall: the key state register is updated on the
// tick's transfer and the classification is then captured in the output
// register, which drives m_tvalid. The input stalls only when an event meets an
// output register that is still waiting to be taken. Configuration writes are
// taken every cycle and should be made while no tick is in flight.

module key_press_classifier
    import kpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Tick input. tdata: [0] pin_level, [7:1] zero.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // Event output. tdata: [1:0] event_type, [7:2] zero.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    key_state_t key_state;
    logic       pending;
    logic       advance;

    // Configuration registers.
    kpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Key state tracking.
    kpc_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .press_low  (cfg.press_low),
        .advance    (advance),
        .pending    (pending),
        .key_state  (key_state)
    );

    // Press classification and output register.
    kpc_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .pending   (pending),
        .key_state (key_state),
        .cfg       (cfg),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* bench/kpc_checker.sv */
`timescale 1ns / 1ps

// Watches the tick, event and configuration channels of the key press
// classifier, keeps its own copy of the key state, and compares every event
// transfer with the oldest predicted event.
module kpc_checker
    import kpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned                errors,
    output int unsigned                outstanding
);

    cfg_t       settings;
    key_state_t key_st;
    event_t     pending_events[$];

    // True on the tick where the current press first reaches the threshold.
    function automatic bit hold_reached(input logic [TIME_W-1:0] limit_ms);
        return key_st.pressed_now && key_st.held_time >= limit_ms &&
               key_st.held_time_before < limit_ms;
    endfunction

    // True on the release tick of a press that lasted within [floor, ceiling).
    function automatic bit released_within(input logic [TIME_W-1:0] floor_ms,
                                           input logic [TIME_W-1:0] ceiling_ms);
        return key_st.pressed_before && !key_st.pressed_now &&
               key_st.held_time_before >= floor_ms &&
               key_st.held_time_before < ceiling_ms;
    endfunction

    // Advance the key state by one tick and queue the event it causes, if any.
    task automatic classify_tick(input logic level);
        logic              pressed;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic              swapped;
        event_t            ev;
        bit                found;

        pressed = settings.press_low ? ~level : level;
        key_st.pressed_before   = key_st.pressed_now;
        key_st.held_time_before = key_st.held_time;
        if (pressed != key_st.pressed_now) begin
            key_st.pressed_now = pressed;
            key_st.held_time   = '0;
        end
        else begin
            sum = {1'b0, key_st.held_time} + (TIME_W + 1)'(TICK_MS);
            key_st.held_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        end

        // Order the long thresholds; the higher one is labeled b until unswapped.
        swapped = settings.long_time_b < settings.long_time_a;
        lo = swapped ? settings.long_time_b : settings.long_time_a;
        hi = swapped ? settings.long_time_a : settings.long_time_b;

        found = 1'b1;
        ev    = EV_SHORT;
        if (hi != '0 && lo != '0) begin
            if (hold_reached(hi))
                ev = EV_LONG_B;
            else if (released_within(lo, hi))
                ev = EV_LONG_A;
            else if (released_within(settings.short_time, lo))
                ev = EV_SHORT;
            else
                found = 1'b0;
        end
        else if (hi != '0) begin
            if (hold_reached(hi))
                ev = EV_LONG_B;
            else if (released_within(settings.short_time, hi))
                ev = EV_SHORT;
            else
                found = 1'b0;
        end
        else if (hold_reached(settings.short_time)) begin
            ev = EV_SHORT;
        end
        else begin
            found = 1'b0;
        end

        if (found) begin
            if (swapped && ev != EV_SHORT)
                ev = (ev == EV_LONG_B) ? EV_LONG_A : EV_LONG_B;
            pending_events.push_back(ev);
        end
    endtask

    // Track register writes, predict on tick transfers, check event transfers.
    always @(posedge clk or negedge rst_n) begin
        event_t want;

        if (!rst_n) begin
            settings.press_low   = 1'b1;
            settings.long_time_a = '0;
            settings.long_time_b = '0;
            settings.short_time  = SHORT_TIME_RESET;
            key_st               = '0;
            pending_events.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PRESS_LOW:   settings.press_low   = cfg_data[0];
                    REG_LONG_TIME_A: settings.long_time_a = cfg_data[TIME_W-1:0];
                    REG_LONG_TIME_B: settings.long_time_b = cfg_data[TIME_W-1:0];
                    REG_SHORT_TIME:  settings.short_time  = cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                classify_tick(s_tdata[0]);

            if (m_tvalid && m_tready) begin
                if (pending_events.size() == 0) begin
                    $error("event_type: unexpected transfer, expected none, actual %0d",
                           m_tdata[1:0]);
                    errors <= errors + 1;
                end
                else begin
                    want = pending_events.pop_front();
                    if (m_tdata[1:0] !== want) begin
                        $error("event_type mismatch: expected %0d, actual %0d",
                               want, m_tdata[1:0]);
                        errors <= errors + 1;
                    end
                end
            end

            outstanding <= pending_events.size();
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import kpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SEG_TICKS    = 84;
    localparam int unsigned DRAIN_CYCLES = 6;
    // Index past the last register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(4);

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // [0] pin_level, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;    // [1:0] event_type, [7:2] zero
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycles = 0;
    int unsigned ticks_sent;
    int unsigned gap_pct;
    int unsigned stall_pct;

    // Settings last written, used to aim press lengths at the thresholds.
    logic              al_now;
    logic [TIME_W-1:0] a_now;
    logic [TIME_W-1:0] b_now;
    logic [TIME_W-1:0] short_now;

    key_press_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kpc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (mismatches),
        .outstanding (outstanding)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Event receiver stalls at random.
    always @(posedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("key_press_classifier verification failed");
            $finish;
        end
    end

    // One tick transfer, after a random idle gap.
    task automatic send_tick(input logic level);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, level};
        do
            @(posedge clk);
        while (!s_tready);
        ticks_sent++;
    endtask

    task automatic hold_level(input logic level, input int unsigned count);
        repeat (count)
            send_tick(level);
    endtask

    // Stop ticks and wait until every predicted event has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // One register write transfer; the caller lowers cfg_valid afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PRESS_LOW:   al_now    = data[0];
            REG_LONG_TIME_A: a_now     = data[TIME_W-1:0];
            REG_LONG_TIME_B: b_now     = data[TIME_W-1:0];
            REG_SHORT_TIME:  short_now = data[TIME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic al, input logic [TIME_W-1:0] a_ms,
                              input logic [TIME_W-1:0] b_ms,
                              input logic [TIME_W-1:0] short_ms);
        drain();
        write_reg(REG_PRESS_LOW, CFG_DATA_W'(al));
        write_reg(REG_LONG_TIME_A, a_ms);
        write_reg(REG_LONG_TIME_B, b_ms);
        write_reg(REG_SHORT_TIME, short_ms);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] pick_long();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return TIME_MAX;
        return TIME_W'($urandom_range(20, 300));
    endfunction

    function automatic logic [TIME_W-1:0] pick_short();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0)
            return '0;
        if (r == 1)
            return TIME_MAX;
        return TIME_W'($urandom_range(10, 120));
    endfunction

    // A press aimed near one of the thresholds, or bounce noise.
    task automatic key_gesture();
        logic              down;
        logic [TIME_W-1:0] target;
        int                len;
        int unsigned       kind;

        down = ~al_now;
        kind = $urandom_range(9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4))
                send_tick(1'($urandom_range(1)));
        end
        else if (kind == 1) begin
            hold_level(down, $urandom_range(1, 2));
            hold_level(~down, 1);
        end
        else begin
            case ($urandom_range(2))
                0:       target = short_now;
                1:       target = a_now;
                default: target = b_now;
            endcase
            if (target > 600)
                target = TIME_W'($urandom_range(600));
            len = int'(target / 10) + int'($urandom_range(4)) - 1;
            if (len < 1)
                len = 1;
            hold_level(down, len);
            hold_level(~down, $urandom_range(1, 5));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        int unsigned start;
        logic [TIME_W-1:0] a_ms;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        ticks_sent = 0;
        gap_pct    = 28;
        stall_pct  = 63;
        al_now     = 1'b1;
        a_now      = '0;
        b_now      = '0;
        short_now  = SHORT_TIME_RESET;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: short press reported while the key is still held.
        hold_level(1'b0, 7);
        hold_level(1'b1, 1);

        // Release between the two long thresholds, in order and swapped.
        set_config(1'b0, 16'd20, 16'd60, 16'd10);
        hold_level(1'b1, 3);
        hold_level(1'b0, 1);
        set_config(1'b0, 16'd60, 16'd20, 16'd10);
        hold_level(1'b1, 3);
        hold_level(1'b0, 1);

        // Equal thresholds: a long hold is reported as threshold b.
        set_config(1'b0, 16'd30, 16'd30, 16'd10);
        hold_level(1'b1, 4);
        hold_level(1'b0, 1);

        // Unused index and upper bits are ignored; all zero never fires.
        drain();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_PRESS_LOW, 16'hFFFE);
        write_reg(REG_SHORT_TIME, 16'd0);
        write_reg(REG_LONG_TIME_A, 16'd0);
        write_reg(REG_LONG_TIME_B, 16'd0);
        cfg_valid <= 1'b0;
        hold_level(1'b1, 3);
        hold_level(1'b0, 1);

        // Random presses under three idling patterns and varied settings.
        for (int mode = 0; mode < 3; mode++) begin
            gap_pct   = (mode == 0) ? 28 : (mode == 1) ? 63 : 0;
            stall_pct = (mode == 0) ? 63 : (mode == 1) ? 28 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                if (seg == 0) begin
                    set_config(mode[0], TIME_MAX, '0, '0);
                end
                else begin
                    a_ms = pick_long();
                    set_config(1'($urandom_range(1)), a_ms,
                               ($urandom_range(5) == 0) ? a_ms : pick_long(),
                               pick_short());
                end
                start = ticks_sent;
                while (ticks_sent - start < SEG_TICKS)
                    key_gesture();
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("key_press_classifier verification clean");
        else
            $display("key_press_classifier verification failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/kpc_pkg.sv
hw/rtl/kpc_cfg.sv
hw/rtl/kpc_track.sv
hw/rtl/kpc_judge.sv
hw/rtl/key_press_classifier.sv
bench/kpc_checker.sv
bench/testbench.sv
